// File: rtl/swsq_pkg.sv
`timescale 1ns / 1ps

package swsq_pkg;

  localparam int SLOT_COUNT_LOG2_DEFAULT = 4;
  localparam int DATA_WIDTH_DEFAULT      = 64;
  localparam int SEQ_WIDTH_DEFAULT       = 32;

  localparam int FUNC_W     = 2;
  localparam int REQ_LEN_W  = 16;
  localparam int LEN_W      = 12;
  localparam int STATUS_W   = 3;

  localparam logic [LEN_W-1:0] CAPACITY_RESET = 12'hFFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_COMMIT  = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_RELEASE = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOCHANGE = 3'd1,
    ST_BELOW    = 3'd2,
    ST_ABOVE    = 3'd3,
    ST_WRONG    = 3'd4,
    ST_TOOLONG  = 3'd5,
    ST_TRUNC    = 3'd6
  } status_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

// File: rtl/swsq_ctrl.sv
`timescale 1ns / 1ps

module swsq_ctrl
  import swsq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output ctrl_cmd_t cmd
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;
  logic   ready;

  assign s_tready    = ready;
  assign cmd.capture = s_tvalid && ready;
  assign cmd.execute = (state == EXEC) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      ready    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          ready <= 1'b1;
          if (cmd.capture) begin
            state <= EXEC;
            ready <= 1'b0;
          end
        end
        EXEC: begin
          if (cmd.execute) begin
            state <= IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= IDLE;
          ready <= 1'b0;
        end
      endcase
      if (cmd.execute) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/swsq_dp.sv
`timescale 1ns / 1ps

module swsq_dp
  import swsq_pkg::*;
#(
  parameter int SLOT_COUNT_LOG2 = SLOT_COUNT_LOG2_DEFAULT,
  parameter int DATA_WIDTH      = DATA_WIDTH_DEFAULT,
  parameter int SEQ_WIDTH       = SEQ_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  input  logic                  cfg_wr_en,
  input  logic [LEN_W-1:0]      cfg_wr_data,
  input  logic [FUNC_W-1:0]     req_func,
  input  logic [SEQ_WIDTH-1:0]  req_seq,
  input  logic [REQ_LEN_W-1:0]  req_len,
  input  logic [DATA_WIDTH-1:0] req_data,
  output logic [STATUS_W-1:0]   res_status,
  output logic [LEN_W-1:0]      res_len,
  output logic [DATA_WIDTH-1:0] res_data,
  output logic [SEQ_WIDTH-1:0]  res_wseq,
  output logic [SEQ_WIDTH-1:0]  res_rseq
);

  localparam int SLOT_COUNT = 1 << SLOT_COUNT_LOG2;
  localparam int DATA_BYTES = DATA_WIDTH / 8;
  localparam int OFF_W      = SLOT_COUNT_LOG2 + 1;

  typedef logic [SLOT_COUNT_LOG2-1:0] idx_t;
  typedef logic [OFF_W-1:0]           off_t;

  logic [LEN_W-1:0]      capacity;
  logic [SEQ_WIDTH-1:0]  rseq;
  logic [SEQ_WIDTH-1:0]  wseq;
  logic [SLOT_COUNT-1:0] full;
  logic [SLOT_COUNT-1:0] pay_vld;

  logic [DATA_WIDTH-1:0] payload_mem [SLOT_COUNT];
  logic [LEN_W-1:0]      length_mem  [SLOT_COUNT];

  func_t                 r_func;
  logic [SEQ_WIDTH-1:0]  r_seq;
  logic [REQ_LEN_W-1:0]  r_len;
  logic [DATA_WIDTH-1:0] r_data;
  logic [DATA_WIDTH-1:0] rd_pay;
  logic [LEN_W-1:0]      rd_len;

  idx_t                  idx;
  logic [SEQ_WIDTH-1:0]  seq_off;
  logic                  in_window;
  status_t               win_status;
  logic                  is_full;
  logic [LEN_W-1:0]      wr_n;
  logic                  trunc;
  logic [LEN_W-1:0]      held;
  logic                  too_long;
  logic [LEN_W-1:0]      rd_n;
  logic [LEN_W-1:0]      sel_n;
  logic [DATA_WIDTH-1:0] mask;
  logic [DATA_WIDTH-1:0] old_pay;
  logic [DATA_WIDTH-1:0] new_pay;
  logic [SLOT_COUNT-1:0] full_next;
  logic                  do_write;
  logic                  do_commit;
  logic                  do_release;
  off_t                  w_off;
  idx_t                  base;
  logic [SLOT_COUNT-1:0] rot;
  logic [SLOT_COUNT-1:0] stop;
  off_t                  cnt;
  status_t               adv_status;
  status_t               status_next;
  logic [LEN_W-1:0]      len_next;
  logic [DATA_WIDTH-1:0] data_next;
  logic [SEQ_WIDTH-1:0]  wseq_next;
  logic [SEQ_WIDTH-1:0]  rseq_next;

  always_comb begin
    idx        = idx_t'(r_seq);
    seq_off    = r_seq - rseq;
    in_window  = (seq_off >> SLOT_COUNT_LOG2) == '0;
    win_status = seq_off[SEQ_WIDTH-1] ? ST_BELOW : ST_ABOVE;
    is_full    = full[idx];
    old_pay    = pay_vld[idx] ? rd_pay : '0;

    trunc    = r_len > REQ_LEN_W'(capacity);
    wr_n     = trunc ? capacity : r_len[LEN_W-1:0];
    held     = is_full ? rd_len : capacity;
    too_long = r_len > REQ_LEN_W'(held);
    rd_n     = (r_len < REQ_LEN_W'(rd_len)) ? r_len[LEN_W-1:0] : rd_len;
    sel_n    = (r_func == FUNC_WRITE) ? wr_n : rd_n;

    for (int b = 0; b < DATA_BYTES; b++) begin
      mask[8*b +: 8] = (sel_n > LEN_W'(b)) ? 8'hFF : 8'h00;
    end
    new_pay = (old_pay & ~mask) | (r_data & mask);

    do_write   = in_window && !is_full && (r_func == FUNC_WRITE);
    do_commit  = in_window && !too_long && !is_full && (r_func == FUNC_COMMIT);
    do_release = in_window && is_full && (r_func == FUNC_RELEASE);

    full_next = full;
    if (do_commit) begin
      full_next[idx] = 1'b1;
    end
    if (do_release) begin
      full_next[idx] = 1'b0;
    end

    // One find-first serves both pointers: a commit walks full slots from the
    // write sequence up to the window end, a release walks empty slots from
    // the read sequence up to the write sequence.
    w_off = off_t'(wseq - rseq);
    base  = (r_func == FUNC_COMMIT) ? idx_t'(wseq) : idx_t'(rseq);
    for (int j = 0; j < SLOT_COUNT; j++) begin
      rot[j] = full_next[idx_t'(base + idx_t'(j))];
      if (r_func == FUNC_COMMIT) begin
        stop[j] = !rot[j] || ((off_t'(j) + w_off) >= off_t'(SLOT_COUNT));
      end else begin
        stop[j] = rot[j] || (off_t'(j) >= w_off);
      end
    end
    cnt = off_t'(SLOT_COUNT);
    for (int j = SLOT_COUNT - 1; j >= 0; j--) begin
      if (stop[j]) begin
        cnt = off_t'(j);
      end
    end
    adv_status = (cnt == '0) ? ST_NOCHANGE : ST_OK;

    wseq_next   = wseq;
    rseq_next   = rseq;
    len_next    = '0;
    data_next   = '0;
    status_next = ST_OK;
    if (!in_window) begin
      status_next = win_status;
    end else begin
      case (r_func)
        FUNC_WRITE: begin
          if (is_full) begin
            status_next = ST_ABOVE;
          end else begin
            status_next = trunc ? ST_TRUNC : ST_OK;
            len_next    = wr_n;
          end
        end
        FUNC_COMMIT: begin
          if (too_long) begin
            status_next = ST_TOOLONG;
          end else if (is_full) begin
            status_next = ST_WRONG;
          end else begin
            status_next = adv_status;
            wseq_next   = wseq + SEQ_WIDTH'(cnt);
          end
        end
        FUNC_READ: begin
          if (!is_full) begin
            status_next = ST_ABOVE;
          end else begin
            len_next  = rd_n;
            data_next = old_pay & mask;
          end
        end
        default: begin
          if (!is_full) begin
            status_next = ST_WRONG;
          end else begin
            status_next = adv_status;
            rseq_next   = rseq + SEQ_WIDTH'(cnt);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
      rseq     <= '0;
      wseq     <= '0;
      full     <= '0;
      pay_vld  <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (cmd.execute) begin
        rseq <= rseq_next;
        wseq <= wseq_next;
        full <= full_next;
        if (do_write) begin
          pay_vld[idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_func <= func_t'(req_func);
      r_seq  <= req_seq;
      r_len  <= req_len;
      r_data <= req_data;
      rd_pay <= payload_mem[idx_t'(req_seq)];
      rd_len <= length_mem[idx_t'(req_seq)];
    end
    if (cmd.execute) begin
      if (do_write) begin
        payload_mem[idx] <= new_pay;
      end
      if (do_commit) begin
        length_mem[idx] <= r_len[LEN_W-1:0];
      end else if (do_release) begin
        length_mem[idx] <= capacity;
      end
      res_status <= status_next;
      res_len    <= len_next;
      res_data   <= data_next;
      res_wseq   <= wseq_next;
      res_rseq   <= rseq_next;
    end
  end

endmodule

// File: rtl/sequence_window_slot_queue_unit.sv
`timescale 1ns / 1ps

// Reorder buffer of 2^SLOT_COUNT_LOG2 slots addressed by sequence number
// within the window that starts at the read sequence. Each word on the
// slave side carries one request (write data, commit, read or release, as
// given in s_tuser) and yields exactly one result word on the master side
// with a status and both sequences as they stand after the request. A
// request is captured, reading the slot's payload and length memories,
// then executed: the slot is updated and, on a commit or release, a
// pointer advances by a single find-first over the slot-full vector. The
// next request is taken while a result waits on the master side; a
// stalled result holds off the execution of the request that follows it.
// The slot capacity may be written only while no request is in flight.
module sequence_window_slot_queue_unit
  import swsq_pkg::*;
#(
  parameter int SLOT_COUNT_LOG2 = SLOT_COUNT_LOG2_DEFAULT,
  parameter int DATA_WIDTH      = DATA_WIDTH_DEFAULT,
  parameter int SEQ_WIDTH       = SEQ_WIDTH_DEFAULT,
  parameter int IN_BITS         = SEQ_WIDTH + REQ_LEN_W + DATA_WIDTH,
  parameter int IN_W            = ((IN_BITS + 7) / 8) * 8,
  parameter int OUT_BITS        = STATUS_W + LEN_W + DATA_WIDTH + 2 * SEQ_WIDTH,
  parameter int OUT_W           = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  // seq, length, write_data
  input  logic [IN_W-1:0]   s_tdata,
  // func
  input  logic [FUNC_W-1:0] s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // status, result_length, read_data, write_seq_now, read_seq_now
  output logic [OUT_W-1:0]  m_tdata
);

  ctrl_cmd_t             cmd;
  logic [STATUS_W-1:0]   res_status;
  logic [LEN_W-1:0]      res_len;
  logic [DATA_WIDTH-1:0] res_data;
  logic [SEQ_WIDTH-1:0]  res_wseq;
  logic [SEQ_WIDTH-1:0]  res_rseq;

  swsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  swsq_dp #(
    .SLOT_COUNT_LOG2 (SLOT_COUNT_LOG2),
    .DATA_WIDTH      (DATA_WIDTH),
    .SEQ_WIDTH       (SEQ_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_func    (s_tuser),
    .req_seq     (s_tdata[SEQ_WIDTH-1:0]),
    .req_len     (s_tdata[SEQ_WIDTH +: REQ_LEN_W]),
    .req_data    (s_tdata[SEQ_WIDTH + REQ_LEN_W +: DATA_WIDTH]),
    .res_status  (res_status),
    .res_len     (res_len),
    .res_data    (res_data),
    .res_wseq    (res_wseq),
    .res_rseq    (res_rseq)
  );

  assign m_tdata = OUT_W'({res_rseq, res_wseq, res_data, res_len, res_status});

endmodule

// File: tb/sv/sequence_window_slot_queue_unit_test.sv
`timescale 1ns / 1ps

module sequence_window_slot_queue_unit_test;
  import swsq_pkg::*;

  localparam int SLOT_LOG2 = SLOT_COUNT_LOG2_DEFAULT;
  localparam int SLOTS = 1 << SLOT_LOG2;
  localparam int DATA_W = DATA_WIDTH_DEFAULT;
  localparam int SEQ_W = SEQ_WIDTH_DEFAULT;
  localparam int IN_W = SEQ_W + REQ_LEN_W + DATA_W;
  localparam int OUT_W = ((STATUS_W + LEN_W + DATA_W + 2 * SEQ_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    status_t status;
    logic [LEN_W-1:0] length;
    logic [DATA_W-1:0] data;
    logic [SEQ_W-1:0] wseq;
    logic [SEQ_W-1:0] rseq;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // seq, length, write_data
  logic [IN_W-1:0] s_tdata = '0;
  // func
  logic [FUNC_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // status, result_length, read_data, write_seq_now, read_seq_now
  logic [OUT_W-1:0] m_tdata;

  logic slot_full [SLOTS];
  logic [LEN_W-1:0] slot_len [SLOTS];
  logic [DATA_W-1:0] slot_payload [SLOTS];
  logic [SEQ_W-1:0] rd_seq;
  logic [SEQ_W-1:0] wr_seq;
  logic [LEN_W-1:0] capacity;

  reply_t pending_replies [$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  sequence_window_slot_queue_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic status_t window_of(logic [SEQ_W-1:0] s);
    logic [SEQ_W-1:0] d;
    d = s - rd_seq;
    if (d < SLOTS) return ST_OK;
    return d[SEQ_W-1] ? ST_BELOW : ST_ABOVE;
  endfunction

  function automatic logic [DATA_W-1:0] byte_mask(int unsigned n);
    if (n >= DATA_W / 8) return '1;
    return (64'h1 << (8 * n)) - 64'h1;
  endfunction

  function automatic status_t advance_write();
    logic [SEQ_W-1:0] s;
    s = wr_seq;
    for (int k = 0; k < SLOTS; k++) begin
      if (window_of(s) != ST_OK || !slot_full[s[SLOT_LOG2-1:0]]) break;
      s = s + 1'b1;
    end
    if (s == wr_seq) return ST_NOCHANGE;
    wr_seq = s;
    return ST_OK;
  endfunction

  function automatic status_t advance_read();
    logic [SEQ_W-1:0] s;
    s = rd_seq;
    for (int k = 0; k < SLOTS; k++) begin
      if (s == wr_seq || slot_full[s[SLOT_LOG2-1:0]]) break;
      s = s + 1'b1;
    end
    if (s == rd_seq) return ST_NOCHANGE;
    rd_seq = s;
    return ST_OK;
  endfunction

  task automatic apply_request(input func_t f, input logic [SEQ_W-1:0] seq,
                               input logic [REQ_LEN_W-1:0] len,
                               input logic [DATA_W-1:0] wd, output reply_t r);
    logic [SLOT_LOG2-1:0] idx;
    status_t w;
    int unsigned n;
    int unsigned held;
    logic [DATA_W-1:0] m;
    idx = seq[SLOT_LOG2-1:0];
    w = window_of(seq);
    r.length = '0;
    r.data = '0;
    case (f)
      FUNC_WRITE: begin
        if (w != ST_OK) r.status = w;
        else if (slot_full[idx]) r.status = ST_ABOVE;
        else begin
          n = (len < capacity) ? len : capacity;
          m = byte_mask(n);
          slot_payload[idx] = (slot_payload[idx] & ~m) | (wd & m);
          r.length = LEN_W'(n);
          r.status = (n < len) ? ST_TRUNC : ST_OK;
        end
      end
      FUNC_COMMIT: begin
        held = slot_full[idx] ? slot_len[idx] : capacity;
        if (w != ST_OK) r.status = w;
        else if (len > held) r.status = ST_TOOLONG;
        else if (slot_full[idx]) r.status = ST_WRONG;
        else begin
          slot_len[idx] = LEN_W'(len);
          slot_full[idx] = 1'b1;
          r.status = advance_write();
        end
      end
      FUNC_READ: begin
        if (w != ST_OK) r.status = w;
        else if (!slot_full[idx]) r.status = ST_ABOVE;
        else begin
          n = (len < slot_len[idx]) ? len : slot_len[idx];
          r.length = LEN_W'(n);
          r.data = slot_payload[idx] & byte_mask(n);
          r.status = ST_OK;
        end
      end
      default: begin
        if (w != ST_OK) r.status = w;
        else if (!slot_full[idx]) r.status = ST_WRONG;
        else begin
          slot_full[idx] = 1'b0;
          slot_len[idx] = capacity;
          r.status = advance_read();
        end
      end
    endcase
    r.wseq = wr_seq;
    r.rseq = rd_seq;
  endtask

  task automatic send_request(input func_t f, input logic [SEQ_W-1:0] seq,
                              input logic [REQ_LEN_W-1:0] len,
                              input logic [DATA_W-1:0] wd);
    int gap;
    reply_t r;
    gap = tx_calm ? 0 : pick_pause();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {wd, len, seq};
    s_tuser <= f;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    apply_request(f, seq, len, wd, r);
    pending_replies.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [LEN_W-1:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    capacity = value;
  endtask

  task automatic report_field(input string name, input logic [DATA_W-1:0] exp_value,
                              input logic [DATA_W-1:0] act_value);
    if (exp_value !== act_value) begin
      mismatch_count++;
      $display("%0t %s expected %0h actual %0h", $time, name, exp_value, act_value);
    end
  endtask

  always @(posedge clk) begin
    reply_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result expected none actual %0h", $time, m_tdata);
      end else begin
        e = pending_replies.pop_front();
        report_field("status", e.status, m_tdata[2:0]);
        report_field("result_length", e.length, m_tdata[14:3]);
        report_field("read_data", e.data, m_tdata[78:15]);
        report_field("write_seq_now", e.wseq, m_tdata[110:79]);
        report_field("read_seq_now", e.rseq, m_tdata[142:111]);
      end
    end
  end

  always @(negedge clk) begin
    logic ready;
    int p;
    if (stall_left > 0) begin
      stall_left--;
      ready = 1'b0;
    end else if (rx_calm) begin
      ready = 1'b1;
    end else begin
      p = pick_pause();
      ready = (p == 0);
      if (p > 0) stall_left = p - 1;
    end
    m_tready <= ready;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_empty_slots_and_window();
    send_request(FUNC_READ, 32'h0, 16'h0005, 64'h0);
    send_request(FUNC_RELEASE, 32'h0, 16'h0, 64'h0);
    send_request(FUNC_WRITE, 32'h0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(FUNC_WRITE, 32'hFFFF_FFFF, 16'h0004, 64'h0123_4567_89AB_CDEF);
    send_request(FUNC_WRITE, 32'h0000_0010, 16'h0004, 64'h0);
    send_request(FUNC_COMMIT, 32'h7FFF_FFFF, 16'h0, 64'h0);
    send_request(FUNC_READ, 32'h8000_0000, 16'h0, 64'h0);
    send_request(FUNC_WRITE, 32'h1, 16'h0003, 64'hA5A5_5A5A_C3C3_3C3C);
  endtask

  task automatic test_commit_and_release();
    send_request(FUNC_COMMIT, 32'h1, 16'h0005, 64'h0);
    send_request(FUNC_COMMIT, 32'h0, 16'h1000, 64'h0);
    send_request(FUNC_COMMIT, 32'h0, 16'h0008, 64'h0);
    send_request(FUNC_COMMIT, 32'h0, 16'h0003, 64'h0);
    send_request(FUNC_COMMIT, 32'h0, 16'h0009, 64'h0);
    send_request(FUNC_WRITE, 32'h0, 16'h0002, 64'h0);
    send_request(FUNC_READ, 32'h0, 16'h0003, 64'h0);
    send_request(FUNC_READ, 32'h0, 16'hFFFF, 64'h0);
    send_request(FUNC_READ, 32'h1, 16'h0000, 64'h0);
    send_request(FUNC_RELEASE, 32'h1, 16'h0, 64'h0);
    send_request(FUNC_RELEASE, 32'h0, 16'h0, 64'h0);
    send_request(FUNC_COMMIT, 32'h0000_0011, 16'h0, 64'h0);
    send_request(FUNC_WRITE, 32'h0000_0012, 16'h0001, 64'h0);
  endtask

  task automatic test_small_capacity();
    set_capacity(12'h000);
    send_request(FUNC_WRITE, rd_seq, 16'h0001, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(FUNC_COMMIT, rd_seq, 16'h0001, 64'h0);
    send_request(FUNC_COMMIT, rd_seq, 16'h0000, 64'h0);
    send_request(FUNC_READ, rd_seq, 16'hFFFF, 64'h0);
  endtask

  task automatic test_random_traffic(input int count);
    func_t f;
    logic [SEQ_W-1:0] seq;
    logic [REQ_LEN_W-1:0] len;
    logic [DATA_W-1:0] wd;
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 149) drain();
      tx_calm = (i % 200 >= 100) && (i % 200 < 130);
      rx_calm = tx_calm;
      f = func_t'($urandom_range(0, 3));
      wd = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 85) begin
        case (f)
          FUNC_COMMIT: seq = wr_seq + $urandom_range(0, 3);
          FUNC_RELEASE: seq = rd_seq + $urandom_range(0, 3);
          default: seq = rd_seq + $urandom_range(0, SLOTS - 1);
        endcase
        r = $urandom_range(0, 99);
        if (r < 15) len = REQ_LEN_W'($urandom_range(0, 16'hFFFF));
        else if (f == FUNC_COMMIT) len = REQ_LEN_W'($urandom_range(0, capacity));
        else len = REQ_LEN_W'($urandom_range(0, 12));
      end else begin
        seq = (r < 92) ? SEQ_W'($urandom) : rd_seq - $urandom_range(1, 4);
        len = REQ_LEN_W'($urandom_range(0, 16'hFFFF));
      end
      send_request(f, seq, len, wd);
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_full[i] = 1'b0;
      slot_len[i] = '0;
      slot_payload[i] = '0;
    end
    rd_seq = '0;
    wr_seq = '0;
    capacity = CAPACITY_RESET;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_slots_and_window();
    test_commit_and_release();
    test_random_traffic(200);
    test_small_capacity();
    test_random_traffic(120);
    set_capacity(12'h001);
    test_random_traffic(120);
    set_capacity(12'h009);
    test_random_traffic(150);
    set_capacity(LEN_W'($urandom_range(0, 12'hFFF)));
    test_random_traffic(200);
    set_capacity(12'hFFF);
    test_random_traffic(200);
    drain();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sequence_window_slot_queue_unit.f
rtl/swsq_pkg.sv
rtl/swsq_ctrl.sv
rtl/swsq_dp.sv
rtl/sequence_window_slot_queue_unit.sv
tb/sv/sequence_window_slot_queue_unit_test.sv
